[rtl/ctlw_pkg.sv]
// ---------------------------------------------------------------------------
// ctlw_pkg
// Shared types and constants of the cotangent Laplacian weights unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ctlw_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

  typedef logic signed [23:0] coord_t;
  typedef logic signed [24:0] vec_t;
  typedef logic [15:0]        vid_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    vid_t   vertex_a;
    vid_t   vertex_b;
    vid_t   vertex_c;
  } tri_in_t;

  typedef struct packed {
    vid_t               row_index;
    vid_t               col_index;
    logic signed [31:0] weight;
    logic               saturated;
    logic               last;
  } entry_t;

  // Edge vectors of one triangle: u = B - A, v = C - A, w = C - B.
  typedef struct packed {
    vec_t ux;
    vec_t uy;
    vec_t uz;
    vec_t vx;
    vec_t vy;
    vec_t vz;
    vec_t wx;
    vec_t wy;
    vec_t wz;
    vid_t id_a;
    vid_t id_b;
    vid_t id_c;
  } edge_item_t;

endpackage

`default_nettype wire

[rtl/triangle_cotangent_laplacian_weights_unit.sv]
// ---------------------------------------------------------------------------
// triangle_cotangent_laplacian_weights_unit
// Nine cotangent Laplacian matrix entries for each queued mesh triangle.
// ---------------------------------------------------------------------------
// A triangle in the back end is first picked up from the front queue. Each
// of its three corners then runs a product pass on one 25x25 multiplier.
// Next come the scaling shifts, the squaring steps and a 32-step square
// root. A corner that is not degenerate or clipped also runs a 32-step
// restoring divider. Finally the nine entries leave one per cycle while the
// result queue is not full. The front end queues two further triangles and
// the result queue holds two entries, so input and output stall
// independently.
`default_nettype none

module triangle_cotangent_laplacian_weights_unit #(
  parameter int FRACTION_BITS = ctlw_pkg::FRACTION_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire ctlw_pkg::tri_in_t item,
  output logic                   empty,
  input  wire logic              pop,
  output ctlw_pkg::entry_t       entry
);

  logic                 q_empty;
  logic                 q_pop;
  ctlw_pkg::edge_item_t q_data;
  logic                 o_push;
  logic                 o_full;
  ctlw_pkg::entry_t     o_entry;

  ctlw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_data)
  );

  ctlw_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_empty  (q_empty),
    .in_pop    (q_pop),
    .in_data   (q_data),
    .out_push  (o_push),
    .out_full  (o_full),
    .out_entry (o_entry)
  );

  ctlw_fifo #(
    .T     (ctlw_pkg::entry_t),
    .DEPTH (ctlw_pkg::QUEUE_DEPTH)
  ) u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (o_push),
    .full     (o_full),
    .data_in  (o_entry),
    .empty    (empty),
    .pop      (pop),
    .data_out (entry)
  );

endmodule

`default_nettype wire

[rtl/ctlw_fifo.sv]
// ---------------------------------------------------------------------------
// ctlw_fifo
// Small synchronous queue with push/full and pop/empty handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module ctlw_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = ctlw_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire T     data_in,
  output logic      empty,
  input  wire logic pop,
  output T          data_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ctlw_front.sv]
// ---------------------------------------------------------------------------
// ctlw_front
// Accepts triangles, forms the edge vectors u, v and w and queues them.
// ---------------------------------------------------------------------------
`default_nettype none

module ctlw_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire ctlw_pkg::tri_in_t    item,
  output logic                      q_empty,
  input  wire logic                 q_pop,
  output ctlw_pkg::edge_item_t      q_data
);

  ctlw_pkg::edge_item_t edges;

  function automatic ctlw_pkg::vec_t sub(input ctlw_pkg::coord_t p, input ctlw_pkg::coord_t q);
    ctlw_pkg::vec_t r;
    r = ctlw_pkg::vec_t'(p) - ctlw_pkg::vec_t'(q);
    return r;
  endfunction

  always_comb begin
    edges.ux   = sub(item.bx, item.ax);
    edges.uy   = sub(item.by_coord, item.ay);
    edges.uz   = sub(item.bz, item.az);
    edges.vx   = sub(item.cx, item.ax);
    edges.vy   = sub(item.cy, item.ay);
    edges.vz   = sub(item.cz, item.az);
    edges.wx   = sub(item.cx, item.bx);
    edges.wy   = sub(item.cy, item.by_coord);
    edges.wz   = sub(item.cz, item.bz);
    edges.id_a = item.vertex_a;
    edges.id_b = item.vertex_b;
    edges.id_c = item.vertex_c;
  end

  ctlw_fifo #(
    .T     (ctlw_pkg::edge_item_t),
    .DEPTH (ctlw_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .data_in  (edges),
    .empty    (q_empty),
    .pop      (q_pop),
    .data_out (q_data)
  );

endmodule

`default_nettype wire

[rtl/ctlw_back.sv]
// ---------------------------------------------------------------------------
// ctlw_back
// Per-corner sequencer: products, scaling, square root, division, emission.
// ---------------------------------------------------------------------------
`default_nettype none

module ctlw_back #(
  parameter int FRACTION_BITS = ctlw_pkg::FRACTION_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_empty,
  output logic                      in_pop,
  input  wire ctlw_pkg::edge_item_t in_data,
  output logic                      out_push,
  input  wire logic                 out_full,
  output ctlw_pkg::entry_t          out_entry
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ABS   = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_SQR   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam int CLIP_SHIFT = 32 - FRACTION_BITS;
  localparam int NUM_SHIFT  = FRACTION_BITS - 1;

  logic [3:0]           state;
  logic [1:0]           corner;
  logic [4:0]           cnt;
  logic [3:0]           k;
  ctlw_pkg::edge_item_t cur;

  logic signed [49:0] prod;
  logic signed [51:0] cr0, cr1, cr2, dot;
  logic [50:0]        a0, a1, a2, d;
  logic               dneg;
  logic [61:0]        sq;
  logic [63:0]        sum;
  logic [63:0]        rem, res, sbit;
  logic [31:0]        drem, dnum;
  logic signed [31:0] h0, h1, h2;
  logic [2:0]         cl;
  logic               deg;

  ctlw_pkg::vec_t     e1x, e1y, e1z, e2x, e2y, e2z;
  ctlw_pkg::vec_t     ma, mb;
  logic signed [49:0] prod_w;
  logic signed [51:0] prod_x;
  logic [30:0]        sq_op;
  logic [63:0]        res_bit;
  logic [31:0]        n;
  logic [63:0]        numer;
  logic [32:0]        r2;
  logic signed [31:0] h_new;
  logic               cl_new;

  // Edge pair for the corner in work; corners 1 and 2 reuse u, v, w, some negated.
  always_comb begin
    unique case (corner)
      2'd0: begin
        e1x = cur.ux;  e1y = cur.uy;  e1z = cur.uz;
        e2x = cur.vx;  e2y = cur.vy;  e2z = cur.vz;
      end
      2'd1: begin
        e1x = cur.wx;  e1y = cur.wy;  e1z = cur.wz;
        e2x = -cur.ux; e2y = -cur.uy; e2z = -cur.uz;
      end
      default: begin
        e1x = -cur.vx; e1y = -cur.vy; e1z = -cur.vz;
        e2x = -cur.wx; e2y = -cur.wy; e2z = -cur.wz;
      end
    endcase
  end

  always_comb begin
    unique case (cnt)
      5'd0:    begin ma = e1y; mb = e2z; end
      5'd1:    begin ma = e1z; mb = e2y; end
      5'd2:    begin ma = e1z; mb = e2x; end
      5'd3:    begin ma = e1x; mb = e2z; end
      5'd4:    begin ma = e1x; mb = e2y; end
      5'd5:    begin ma = e1y; mb = e2x; end
      5'd7:    begin ma = e1y; mb = e2y; end
      5'd8:    begin ma = e1z; mb = e2z; end
      default: begin ma = e1x; mb = e2x; end
    endcase
  end

  assign prod_w = ma * mb;
  assign prod_x = 52'(prod);

  always_comb begin
    unique case (cnt)
      5'd0:    sq_op = a0[30:0];
      5'd1:    sq_op = a1[30:0];
      default: sq_op = a2[30:0];
    endcase
  end

  assign res_bit = res + sbit;
  assign n       = res[31:0];
  assign numer   = (64'(d) << NUM_SHIFT) + 64'(n >> 1);
  assign r2      = {drem, dnum[31]};

  always_comb begin
    cl_new = 1'b0;
    if (dneg) begin
      h_new = 32'(-$signed({1'b0, dnum}));
    end else if (dnum[31]) begin
      h_new  = ctlw_pkg::W_MAX;
      cl_new = 1'b1;
    end else begin
      h_new = $signed(dnum);
    end
  end

  // Emission table: six off-diagonal entries, then three diagonal ones.
  logic               diag;
  logic signed [31:0] ox, oy;
  logic               of;
  ctlw_pkg::vid_t     orow, ocol;
  logic signed [32:0] val;

  always_comb begin
    diag = 1'b0;
    oy   = '0;
    unique case (k)
      4'd0: begin orow = cur.id_b; ocol = cur.id_c; ox = h0; of = cl[0]; end
      4'd1: begin orow = cur.id_c; ocol = cur.id_b; ox = h0; of = cl[0]; end
      4'd2: begin orow = cur.id_c; ocol = cur.id_a; ox = h1; of = cl[1]; end
      4'd3: begin orow = cur.id_a; ocol = cur.id_c; ox = h1; of = cl[1]; end
      4'd4: begin orow = cur.id_a; ocol = cur.id_b; ox = h2; of = cl[2]; end
      4'd5: begin orow = cur.id_b; ocol = cur.id_a; ox = h2; of = cl[2]; end
      4'd6: begin
        orow = cur.id_a; ocol = cur.id_a; ox = h1; oy = h2; of = cl[1] | cl[2]; diag = 1'b1;
      end
      4'd7: begin
        orow = cur.id_b; ocol = cur.id_b; ox = h2; oy = h0; of = cl[2] | cl[0]; diag = 1'b1;
      end
      default: begin
        orow = cur.id_c; ocol = cur.id_c; ox = h0; oy = h1; of = cl[0] | cl[1]; diag = 1'b1;
      end
    endcase
    val = diag ? (33'(ox) + 33'(oy)) : -33'(ox);
    out_entry.row_index = orow;
    out_entry.col_index = ocol;
    out_entry.last      = (k == 4'd8);
    if (val > 33'(ctlw_pkg::W_MAX)) begin
      out_entry.weight    = ctlw_pkg::W_MAX;
      out_entry.saturated = 1'b1;
    end else if (val < 33'(ctlw_pkg::W_MIN)) begin
      out_entry.weight    = ctlw_pkg::W_MIN;
      out_entry.saturated = 1'b1;
    end else begin
      out_entry.weight    = val[31:0];
      out_entry.saturated = of | deg;
    end
  end

  assign in_pop   = (state == S_IDLE) && !in_empty;
  assign out_push = (state == S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      corner <= '0;
      cnt    <= '0;
      k      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!in_empty) begin
            cur    <= in_data;
            corner <= '0;
            cnt    <= '0;
            deg    <= 1'b0;
            cl     <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= prod_w;
          if (cnt != 5'd0) begin
            unique case (cnt)
              5'd1:    cr0 <= prod_x;
              5'd2:    cr0 <= cr0 - prod_x;
              5'd3:    cr1 <= prod_x;
              5'd4:    cr1 <= cr1 - prod_x;
              5'd5:    cr2 <= prod_x;
              5'd6:    cr2 <= cr2 - prod_x;
              5'd7:    dot <= prod_x;
              default: dot <= dot + prod_x;
            endcase
          end
          if (cnt == 5'd9) begin
            state <= S_ABS;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ABS: begin
          a0    <= cr0[51] ? 51'(-cr0) : 51'(cr0);
          a1    <= cr1[51] ? 51'(-cr1) : 51'(cr1);
          a2    <= cr2[51] ? 51'(-cr2) : 51'(cr2);
          d     <= dot[51] ? 51'(-dot) : 51'(dot);
          dneg  <= dot[51];
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // Truncating right shift until every cross magnitude fits 31 bits.
          if (|{a0[50:31], a1[50:31], a2[50:31]}) begin
            a0 <= a0 >> 1;
            a1 <= a1 >> 1;
            a2 <= a2 >> 1;
            d  <= d >> 1;
          end else begin
            cnt   <= '0;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          sq <= sq_op * sq_op;
          if (cnt == 5'd1) begin
            sum <= 64'(sq);
          end else if (cnt == 5'd2) begin
            sum <= sum + 64'(sq);
          end
          if (cnt == 5'd3) begin
            rem   <= sum + 64'(sq);
            res   <= '0;
            sbit  <= 64'h4000_0000_0000_0000;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          if (rem >= res_bit) begin
            rem <= rem - res_bit;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          if (cnt == 5'd31) begin
            state <= S_CHECK;
          end
          cnt <= cnt + 1'b1;
        end
        S_CHECK: begin
          if (n == '0) begin
            deg   <= 1'b1;
            dnum  <= dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            state <= S_FIN;
          end else if (64'(d) >= (64'(n) << CLIP_SHIFT)) begin
            cl[corner] <= 1'b1;
            dnum       <= dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            state      <= S_FIN;
          end else begin
            drem  <= numer[63:32];
            dnum  <= numer[31:0];
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle into dnum.
          if (r2 >= {1'b0, n}) begin
            drem <= 32'(r2 - {1'b0, n});
            dnum <= {dnum[30:0], 1'b1};
          end else begin
            drem <= r2[31:0];
            dnum <= {dnum[30:0], 1'b0};
          end
          if (cnt == 5'd31) begin
            state <= S_FIN;
          end
          cnt <= cnt + 1'b1;
        end
        S_FIN: begin
          // Saturated cases already hold the final magnitude pattern; negation
          // of 2^31 maps to the minimum and 2^31-1 stays at the maximum.
          unique case (corner)
            2'd0:    h0 <= h_new;
            2'd1:    h1 <= h_new;
            default: h2 <= h_new;
          endcase
          if (cl_new) begin
            cl[corner] <= 1'b1;
          end
          cnt <= '0;
          if (corner == 2'd2) begin
            k     <= '0;
            state <= S_EMIT;
          end else begin
            corner <= corner + 1'b1;
            state  <= S_MUL;
          end
        end
        S_EMIT: begin
          if (!out_full) begin
            if (k == 4'd8) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sim/triangle_cotangent_laplacian_weights_unit_test.sv]
// ---------------------------------------------------------------------------
// triangle_cotangent_laplacian_weights_unit_test
// Sends triangles through the queue interface and checks all nine matrix
// entries of each against a fixed-point prediction, under random stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_cotangent_laplacian_weights_unit_test;

  localparam longint LIMIT_CYCLES = 2000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  ctlw_pkg::tri_in_t item = '0;
  logic              empty;
  logic              pop = 1'b0;
  ctlw_pkg::entry_t  entry;

  ctlw_pkg::entry_t  entry_q[$];
  int                errors = 0;
  longint            cycles = 0;
  bit                calm = 1'b0;
  int                pop_hold = 0;

  triangle_cotangent_laplacian_weights_unit u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .entry(entry)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("triangle_cotangent_laplacian_weights_unit_test: done, errors");
      $finish;
    end
  end

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Half cotangent at corner pi in Q16, with degenerate and clip flags.
  function automatic longint half_cotangent(longint pi[3], longint pj[3], longint pk[3],
                                            inout bit deg, inout bit clip);
    longint e1[3], e2[3], cr[3], dotp;
    longint unsigned mags[3], mx, sum, n, d, q, sv;
    int s, t;
    for (t = 0; t < 3; t++) begin
      e1[t] = pj[t] - pi[t];
      e2[t] = pk[t] - pi[t];
    end
    dotp = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    mx = 0;
    for (t = 0; t < 3; t++) begin
      mags[t] = abs64(cr[t]);
      if (mags[t] > mx) mx = mags[t];
    end
    s = 0;
    while ((mx >> s) >= (64'd1 << 31)) s++;
    sum = 0;
    for (t = 0; t < 3; t++) begin
      sv = mags[t] >> s;
      sum += sv * sv;
    end
    n = root64(sum);
    if (n == 0) begin
      deg = 1;
      return dotp >= 0 ? 64'sd2147483647 : -64'sd2147483648;
    end
    d = abs64(dotp) >> s;
    if (d >= (n << (32 - ctlw_pkg::FRACTION_BITS))) begin
      clip = 1;
      return dotp >= 0 ? 64'sd2147483647 : -64'sd2147483648;
    end
    q = ((d << (ctlw_pkg::FRACTION_BITS - 1)) + (n >> 1)) / n;
    if (dotp < 0) return sat32(-longint'(q), clip);
    return sat32(longint'(q), clip);
  endfunction

  task automatic predict_entries(ctlw_pkg::tri_in_t tr);
    longint p[3][3], h[3], w;
    ctlw_pkg::vid_t id[3];
    bit deg, cl[3], f;
    ctlw_pkg::entry_t e;
    int i, j, m, k;
    p[0] = '{tr.ax, tr.ay, tr.az};
    p[1] = '{tr.bx, tr.by_coord, tr.bz};
    p[2] = '{tr.cx, tr.cy, tr.cz};
    id = '{tr.vertex_a, tr.vertex_b, tr.vertex_c};
    deg = 0;
    for (i = 0; i < 3; i++) begin
      cl[i] = 0;
      h[i] = half_cotangent(p[i], p[(i + 1) % 3], p[(i + 2) % 3], deg, cl[i]);
    end
    k = 0;
    for (i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      m = (i + 2) % 3;
      f = cl[i];
      w = sat32(-h[i], f);
      e = '{row_index: id[j], col_index: id[m], weight: w[31:0],
            saturated: f | deg, last: 1'b0};
      entry_q = {entry_q, e};
      e.row_index = id[m];
      e.col_index = id[j];
      entry_q = {entry_q, e};
    end
    for (i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      m = (i + 2) % 3;
      f = cl[j] | cl[m];
      w = sat32(h[j] + h[m], f);
      e = '{row_index: id[i], col_index: id[i], weight: w[31:0],
            saturated: f | deg, last: (i == 2)};
      entry_q = {entry_q, e};
    end
  endtask

  // Sends one triangle; the beat is predicted when it is accepted. Push stays
  // high afterwards so that the next beat can follow without a gap.
  task automatic send_triangle(ctlw_pkg::tri_in_t tr);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= tr;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_entries(tr);
  endtask

  // Result side: random pop stalls, check on each accepted beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (entry_q.size() == 0) begin
          $display("%0t: unexpected entry %h", $time, entry);
          errors++;
        end else if (entry_q[0] !== entry) begin
          $display("%0t: entry mismatch expected %h actual %h", $time, entry_q[0], entry);
          errors++;
          void'(entry_q.pop_front());
        end else begin
          void'(entry_q.pop_front());
        end
      end
      if (pop_hold > 0) begin
        pop_hold <= pop_hold - 1;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop_hold <= $urandom_range(1, 16) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic ctlw_pkg::tri_in_t random_triangle(int span);
    ctlw_pkg::tri_in_t tr;
    logic [287:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    tr = ctlw_pkg::tri_in_t'(raw[263:0]);
    if (span < 24) begin
      tr.ax = $signed(tr.ax) >>> (24 - span);
      tr.ay = $signed(tr.ay) >>> (24 - span);
      tr.az = $signed(tr.az) >>> (24 - span);
      tr.bx = $signed(tr.bx) >>> (24 - span);
      tr.by_coord = $signed(tr.by_coord) >>> (24 - span);
      tr.bz = $signed(tr.bz) >>> (24 - span);
      tr.cx = $signed(tr.cx) >>> (24 - span);
      tr.cy = $signed(tr.cy) >>> (24 - span);
      tr.cz = $signed(tr.cz) >>> (24 - span);
    end
    return tr;
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    ctlw_pkg::tri_in_t tr;
    ctlw_pkg::coord_t one;
    one = 24'sh010000;
    // Right triangle in the xy plane.
    tr = '0;
    tr.bx = one;
    tr.cy = one;
    tr.vertex_a = 16'd0;
    tr.vertex_b = 16'd1;
    tr.vertex_c = 16'd2;
    send_triangle(tr);
    // Zero area: all corners equal, then collinear corners.
    tr = '0;
    tr.vertex_a = 16'hFFFF;
    tr.vertex_b = 16'hFFFF;
    tr.vertex_c = 16'hFFFF;
    send_triangle(tr);
    tr = '0;
    tr.bx = one;
    tr.cx = -one;
    send_triangle(tr);
    tr = '0;
    tr.bx = one;
    tr.cx = 24'sh020000;
    send_triangle(tr);
    // Very flat triangle gives a clipped cotangent.
    tr = '0;
    tr.ax = -24'sh7FFFFF;
    tr.bx = 24'sh7FFFFF;
    tr.cy = 24'sh000001;
    tr.vertex_a = 16'h8000;
    tr.vertex_b = 16'h7FFF;
    tr.vertex_c = 16'h0001;
    send_triangle(tr);
    // Full-scale coordinates, extremes of every field.
    tr = '0;
    tr.ax = 24'sh800000;
    tr.ay = 24'sh800000;
    tr.az = 24'sh800000;
    tr.bx = 24'sh7FFFFF;
    tr.by_coord = 24'sh800000;
    tr.bz = 24'sh7FFFFF;
    tr.cx = 24'sh800000;
    tr.cy = 24'sh7FFFFF;
    tr.cz = 24'sh7FFFFF;
    tr.vertex_a = 16'hFFFF;
    tr.vertex_b = 16'h0000;
    tr.vertex_c = 16'hAAAA;
    send_triangle(tr);
    tr = ctlw_pkg::tri_in_t'(~tr);
    send_triangle(tr);
    // Smallest nonzero triangle.
    tr = '0;
    tr.bx = 24'sh000001;
    tr.cy = 24'sh000001;
    send_triangle(tr);
    // Obtuse triangle, negative cotangent.
    tr = '0;
    tr.bx = one;
    tr.cx = -one;
    tr.cy = 24'sh000100;
    send_triangle(tr);
    for (int i = 0; i < 6; i++) send_triangle(random_triangle(24));
  endtask

  task automatic test_pause();
    for (int i = 0; i < 4; i++) send_triangle(random_triangle(20));
    // Hold the sender until every expected entry is out.
    wait_drained();
    for (int i = 0; i < 3; i++) send_triangle(random_triangle(12));
  endtask

  task automatic test_random();
    int span;
    for (int i = 0; i < 80; i++) begin
      span = $urandom_range(2, 24);
      send_triangle(random_triangle(span));
    end
  endtask

  task automatic test_no_idle();
    calm = 1'b1;
    for (int i = 0; i < 15; i++) send_triangle(random_triangle($urandom_range(4, 24)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pause();
    test_random();
    test_no_idle();
    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0 && entry_q.size() == 0) begin
      $display("triangle_cotangent_laplacian_weights_unit_test: done, clean");
    end else begin
      $display("triangle_cotangent_laplacian_weights_unit_test: done, errors");
    end
    $finish;
  end

endmodule
